>>> hdl/sta_pkg.sv
// typewriter terminal adapter: shared types, codes and the character table
// no dependencies; used by every other file of the adapter but sta_if

package sta_pkg;

    // bus command codes
    localparam logic [2:0] ACT_READ    = 3'd0;
    localparam logic [2:0] ACT_WRITE   = 3'd1;
    localparam logic [2:0] ACT_SENSE   = 3'd2;
    localparam logic [2:0] ACT_CONTROL = 3'd3;
    localparam logic [2:0] ACT_TICK    = 3'd4;

    // tick schedule codes
    localparam logic [1:0] SCHED_NONE = 2'd0;
    localparam logic [1:0] SCHED_SEND = 2'd1;
    localparam logic [1:0] SCHED_RECV = 2'd2;

    // device status word bits
    localparam logic [15:0] DSW_TX_NOT_READY = 16'h4000;
    localparam logic [15:0] DSW_READ_RESP    = 16'h1000;
    localparam logic [15:0] DSW_OVERRUN      = 16'h0800;
    localparam logic [15:0] DSW_ATTENTION    = 16'h0010;

    // typewriter codes, high byte aligned
    localparam logic [15:0] TC_SHIFT_UP   = 16'h1C00;
    localparam logic [15:0] TC_SHIFT_DOWN = 16'h7C00;
    localparam logic [15:0] TC_CIRCLE_C   = 16'h1F00;
    localparam logic [15:0] TC_CIRCLE_D   = 16'h1600;
    localparam logic [15:0] TC_RETURN     = 16'h5B00;
    localparam logic [15:0] TC_LINE_FEED  = 16'h3B00;
    localparam logic [15:0] TC_NONE       = 16'hFF00;

    // host characters with special handling
    localparam logic [7:0] ASCII_ETB = 8'h17;
    localparam logic [7:0] ASCII_NL  = 8'h0A;
    localparam logic [7:0] ASCII_NUL = 8'h00;

    // status flag positions
    localparam int FLG_RR = 0;
    localparam int FLG_OV = 1;
    localparam int FLG_AT = 2;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] write_code;
        logic       reset_interrupt;
        logic [7:0] host_char;
        logic       host_data_available;
    } cmd_t;

    typedef struct packed {
        logic [7:0]  read_code;
        logic [15:0] status_word;
        logic        interrupt_request;
        logic [1:0]  schedule_tick;
        logic        upper_shift;
    } rsp_t;

    // one table hit: plain codes need no shift, shifted ones name their case
    typedef struct packed {
        logic       hit;
        logic       shifted;
        logic       upper;
        logic [7:0] code;
    } xlate_ent_t;

    function automatic xlate_ent_t char_lookup(input logic [7:0] ch);
        xlate_ent_t e;
        e = '{hit: 1'b1, shifted: 1'b1, upper: 1'b0, code: 8'h00};
        case (ch)
            // plain keys
            8'h20: begin e.shifted = 1'b0; e.code = 8'h01; end
            8'h0D: begin e.shifted = 1'b0; e.code = 8'h5B; end
            8'h08: begin e.shifted = 1'b0; e.code = 8'h5D; end
            8'h09: begin e.shifted = 1'b0; e.code = 8'h5E; end
            // lower case of the typewriter
            8'h41: e.code = 8'h4F;
            8'h42: e.code = 8'h37;
            8'h43: e.code = 8'h2F;
            8'h44: e.code = 8'h2A;
            8'h45: e.code = 8'h29;
            8'h46: e.code = 8'h67;
            8'h47: e.code = 8'h62;
            8'h48: e.code = 8'h32;
            8'h49: e.code = 8'h4C;
            8'h4A: e.code = 8'h61;
            8'h4B: e.code = 8'h2C;
            8'h4C: e.code = 8'h31;
            8'h4D: e.code = 8'h43;
            8'h4E: e.code = 8'h25;
            8'h4F: e.code = 8'h51;
            8'h50: e.code = 8'h68;
            8'h51: e.code = 8'h6D;
            8'h52: e.code = 8'h4A;
            8'h53: e.code = 8'h52;
            8'h54: e.code = 8'h20;
            8'h55: e.code = 8'h26;
            8'h56: e.code = 8'h46;
            8'h57: e.code = 8'h57;
            8'h58: e.code = 8'h23;
            8'h59: e.code = 8'h73;
            8'h5A: e.code = 8'h15;
            8'h30: e.code = 8'h13;
            8'h31: e.code = 8'h02;
            8'h32: e.code = 8'h04;
            8'h33: e.code = 8'h07;
            8'h34: e.code = 8'h10;
            8'h35: e.code = 8'h08;
            8'h36: e.code = 8'h0D;
            8'h37: e.code = 8'h0B;
            8'h38: e.code = 8'h0E;
            8'h39: e.code = 8'h16;
            8'h2F: e.code = 8'h70;
            8'h2B: e.code = 8'h76;
            8'h3F: e.code = 8'h64;
            8'h3C: e.code = 8'h40;
            8'h5B: e.code = 8'h6B;
            8'h5D: e.code = 8'h49;
            8'h2C: e.code = 8'h6E;
            8'h2E: e.code = 8'h45;
            // upper case of the typewriter
            8'h61: begin e.upper = 1'b1; e.code = 8'h4F; end
            8'h62: begin e.upper = 1'b1; e.code = 8'h37; end
            8'h63: begin e.upper = 1'b1; e.code = 8'h2F; end
            8'h64: begin e.upper = 1'b1; e.code = 8'h2A; end
            8'h65: begin e.upper = 1'b1; e.code = 8'h29; end
            8'h5F: begin e.upper = 1'b1; e.code = 8'h67; end
            8'h67: begin e.upper = 1'b1; e.code = 8'h62; end
            8'h68: begin e.upper = 1'b1; e.code = 8'h32; end
            8'h69: begin e.upper = 1'b1; e.code = 8'h4C; end
            8'h6A: begin e.upper = 1'b1; e.code = 8'h61; end
            8'h27: begin e.upper = 1'b1; e.code = 8'h2C; end
            8'h6C: begin e.upper = 1'b1; e.code = 8'h31; end
            8'h7C: begin e.upper = 1'b1; e.code = 8'h16; end
            8'h6E: begin e.upper = 1'b1; e.code = 8'h25; end
            8'h6F: begin e.upper = 1'b1; e.code = 8'h51; end
            8'h2A: begin e.upper = 1'b1; e.code = 8'h68; end
            8'h72: begin e.upper = 1'b1; e.code = 8'h4A; end
            8'h73: begin e.upper = 1'b1; e.code = 8'h52; end
            8'h7E: begin e.upper = 1'b1; e.code = 8'h20; end
            8'h75: begin e.upper = 1'b1; e.code = 8'h26; end
            8'h76: begin e.upper = 1'b1; e.code = 8'h46; end
            8'h77: begin e.upper = 1'b1; e.code = 8'h57; end
            8'h78: begin e.upper = 1'b1; e.code = 8'h23; end
            8'h79: begin e.upper = 1'b1; e.code = 8'h73; end
            8'h7A: begin e.upper = 1'b1; e.code = 8'h15; end
            8'h26: begin e.upper = 1'b1; e.code = 8'h13; end
            8'h3D: begin e.upper = 1'b1; e.code = 8'h08; end
            8'h3E: begin e.upper = 1'b1; e.code = 8'h40; end
            8'h5C: begin e.upper = 1'b1; e.code = 8'h70; end
            8'h2D: begin e.upper = 1'b1; e.code = 8'h76; end
            8'h28: begin e.upper = 1'b1; e.code = 8'h6B; end
            8'h29: begin e.upper = 1'b1; e.code = 8'h49; end
            8'h3B: begin e.upper = 1'b1; e.code = 8'h6E; end
            8'h3A: begin e.upper = 1'b1; e.code = 8'h45; end
            default: e.hit = 1'b0;
        endcase
        return e;
    endfunction

    function automatic logic [15:0] status_value(input logic online, input logic busy,
                                                 input logic [2:0] flags);
        logic [15:0] w;
        w = '0;
        if (!online || busy) w = w | DSW_TX_NOT_READY;
        if (flags[FLG_RR])   w = w | DSW_READ_RESP;
        if (flags[FLG_OV])   w = w | DSW_OVERRUN;
        if (flags[FLG_AT])   w = w | DSW_ATTENTION;
        return w;
    endfunction

endpackage

>>> hdl/sta_if.sv
// typewriter terminal adapter: command and response channel interfaces
// depends on nothing; field names follow the adapter's item layout

interface sta_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] write_code;
    logic       reset_interrupt;
    logic [7:0] host_char;
    logic       host_data_available;

    modport source (output valid, action, write_code, reset_interrupt, host_char,
                    host_data_available, input ready);
    modport sink   (input valid, action, write_code, reset_interrupt, host_char,
                    host_data_available, output ready);
endinterface

interface sta_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_code;
    logic [15:0] status_word;
    logic        interrupt_request;
    logic [1:0]  schedule_tick;
    logic        upper_shift;

    modport source (output valid, read_code, status_word, interrupt_request,
                    schedule_tick, upper_shift, input ready);
    modport sink   (input valid, read_code, status_word, interrupt_request,
                    schedule_tick, upper_shift, output ready);
endinterface

>>> hdl/selectric_terminal_adapter.sv
// typewriter terminal adapter top level: input register, core, result queue
// depends on sta_pkg, sta_if (sta_cmd_if, sta_rsp_if) and sta_core
//
//   channel   dir   contents
//   cmd       in    action, write_code, reset_interrupt, host_char, host_data_available
//   rsp       out   read_code, status_word, interrupt_request, schedule_tick, upper_shift
//   cfg       in    cfg_we / cfg_wdata: online flag
//
// one beat per cycle sustained while rsp takes results; a beat is registered
// in the input register, stepped through the adapter state once the queue has
// room and lands in a two-entry result queue, from which rsp presents it.
// reset clears all adapter state and empties the input register and queue.
// a stalled rsp fills the queue, then holds the input register and drops cmd.ready.

module selectric_terminal_adapter
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    sta_cmd_if.sink    cmd,
    sta_rsp_if.source  rsp
);

    logic          stage_valid_reg;
    sta_pkg::cmd_t stage_item_reg;
    logic          stage_fire;
    logic          cmd_fire;
    sta_pkg::rsp_t step_result;
    sta_pkg::rsp_t q_mem_reg [2];
    logic [1:0]    q_cnt_reg, q_cnt_next;
    logic          q_wr_reg;
    logic          q_rd_reg;
    logic          q_pop;
    sta_pkg::rsp_t q_head;

    // input register handshake
    assign stage_fire = stage_valid_reg && (q_cnt_reg != 2'd2);
    assign cmd.ready  = !stage_valid_reg || stage_fire;
    assign cmd_fire   = cmd.valid && cmd.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (cmd.ready)
            stage_valid_reg <= cmd.valid;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            stage_item_reg.action              <= cmd.action;
            stage_item_reg.write_code          <= cmd.write_code;
            stage_item_reg.reset_interrupt     <= cmd.reset_interrupt;
            stage_item_reg.host_char           <= cmd.host_char;
            stage_item_reg.host_data_available <= cmd.host_data_available;
        end
    end

    sta_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .step_en   (stage_fire),
        .item      (stage_item_reg),
        .result    (step_result)
    );

    // result queue
    assign q_pop  = rsp.valid && rsp.ready;
    assign q_head = q_mem_reg[q_rd_reg];

    always_comb
    begin
        q_cnt_next = q_cnt_reg;
        if (stage_fire && !q_pop)
            q_cnt_next = q_cnt_reg + 2'd1;
        else if (!stage_fire && q_pop)
            q_cnt_next = q_cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_cnt_reg <= '0;
            q_wr_reg  <= 1'b0;
            q_rd_reg  <= 1'b0;
        end
        else
        begin
            q_cnt_reg <= q_cnt_next;
            if (stage_fire)
                q_wr_reg <= !q_wr_reg;
            if (q_pop)
                q_rd_reg <= !q_rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_fire)
            q_mem_reg[q_wr_reg] <= step_result;
    end

    // response port
    assign rsp.valid             = (q_cnt_reg != 2'd0);
    assign rsp.read_code         = q_head.read_code;
    assign rsp.status_word       = q_head.status_word;
    assign rsp.interrupt_request = q_head.interrupt_request;
    assign rsp.schedule_tick     = q_head.schedule_tick;
    assign rsp.upper_shift       = q_head.upper_shift;

    // queue never holds more than two results
    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_cnt_reg != 2'd3)
        else $error("result queue overflow");

    // a stepped beat always leaves a result behind
    a_step_lands: assert property (@(posedge clk) disable iff (!rst_n)
        stage_fire |=> q_cnt_reg != 2'd0)
        else $error("stepped beat lost");

    // a held beat stays in the input register
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg && !stage_fire |=> stage_valid_reg)
        else $error("input beat dropped while stalled");

    // a pop without a push shrinks the queue by one
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && !stage_fire |=> q_cnt_reg == $past(q_cnt_reg) - 2'd1)
        else $error("queue count mismatch on pop");

endmodule

>>> hdl/sta_xlate.sv
// typewriter terminal adapter: host character to typewriter code translation
// depends on sta_pkg (character table)

module sta_xlate
(
    input  logic [7:0]  ch,
    input  logic        shift_up,
    output logic [15:0] codes,
    output logic        shift_up_next
);

    sta_pkg::xlate_ent_t ent;

    assign ent = sta_pkg::char_lookup(ch);

    // pick one code, a shift prefix followed by the code, or return and circle C for a newline; none for NUL or a miss
    always_comb
    begin
        codes         = '0;
        shift_up_next = shift_up;
        if (ch == sta_pkg::ASCII_NL)
        begin
            codes = sta_pkg::TC_RETURN | {8'h00, sta_pkg::TC_CIRCLE_C[15:8]};
        end
        else if (ch == sta_pkg::ASCII_NUL || !ent.hit)
        begin
            codes = '0;
        end
        else if (!ent.shifted)
        begin
            codes = {ent.code, 8'h00};
        end
        else if (!ent.upper)
        begin
            if (shift_up)
            begin
                codes         = {sta_pkg::TC_SHIFT_DOWN[15:8], ent.code};
                shift_up_next = 1'b0;
            end
            else
            begin
                codes = {ent.code, 8'h00};
            end
        end
        else
        begin
            if (!shift_up)
            begin
                codes         = {sta_pkg::TC_SHIFT_UP[15:8], ent.code};
                shift_up_next = 1'b1;
            end
            else
            begin
                codes = {ent.code, 8'h00};
            end
        end
    end

endmodule

>>> hdl/sta_core.sv
// typewriter terminal adapter: adapter state and per-command step logic
// depends on sta_pkg and sta_xlate

module sta_core
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_wdata,
    input  logic          step_en,
    input  sta_pkg::cmd_t item,
    output sta_pkg::rsp_t result
);

    logic        online_reg;
    logic [15:0] pending_reg, pending_next;
    logic        ov_armed_reg, ov_armed_next;
    logic        shift_up_reg, shift_up_next;
    logic        busy_reg, busy_next;
    logic        rx_mode_reg, rx_mode_next;
    logic [2:0]  flags_reg, flags_next;
    logic        irq_reg, irq_next;
    logic [15:0] xl_codes;
    logic        xl_shift;
    logic [1:0]  sched;
    logic [7:0]  rcode;

    sta_xlate u_xlate
    (
        .ch            (item.host_char),
        .shift_up      (shift_up_reg),
        .codes         (xl_codes),
        .shift_up_next (xl_shift)
    );

    // next state of one command or tick
    always_comb
    begin
        pending_next  = pending_reg;
        ov_armed_next = ov_armed_reg;
        shift_up_next = shift_up_reg;
        busy_next     = busy_reg;
        rx_mode_next  = rx_mode_reg;
        flags_next    = flags_reg;
        irq_next      = irq_reg;
        sched         = sta_pkg::SCHED_NONE;
        rcode         = '0;
        unique case (item.action)
            sta_pkg::ACT_READ:
            begin
                rcode         = pending_reg[15:8];
                ov_armed_next = 1'b0;
            end
            sta_pkg::ACT_WRITE:
            begin
                busy_next = 1'b1;
                if ({item.write_code, 8'h00} == sta_pkg::TC_SHIFT_UP)
                    shift_up_next = 1'b1;
                else if ({item.write_code, 8'h00} == sta_pkg::TC_SHIFT_DOWN)
                    shift_up_next = 1'b0;
                sched = sta_pkg::SCHED_SEND;
            end
            sta_pkg::ACT_SENSE:
            begin
                if (item.reset_interrupt)
                begin
                    flags_next[sta_pkg::FLG_RR] = 1'b0;
                    irq_next                    = 1'b0;
                end
            end
            sta_pkg::ACT_CONTROL:
            begin
                rx_mode_next = 1'b1;
                if (online_reg && (pending_reg != '0 || item.host_data_available))
                begin
                    sched        = sta_pkg::SCHED_RECV;
                    pending_next = {8'h00, sta_pkg::TC_CIRCLE_D[15:8]};
                end
            end
            sta_pkg::ACT_TICK:
            begin
                busy_next = 1'b0;
                if (rx_mode_reg)
                begin
                    // shift out the delivered code, refill from the host when empty
                    pending_next = {pending_reg[7:0], 8'h00};
                    if (pending_next == '0 && online_reg && item.host_data_available)
                    begin
                        if (item.host_char == sta_pkg::ASCII_ETB)
                        begin
                            pending_next                = sta_pkg::TC_LINE_FEED;
                            flags_next[sta_pkg::FLG_AT] = 1'b1;
                        end
                        else
                        begin
                            pending_next  = xl_codes;
                            shift_up_next = xl_shift;
                        end
                    end
                    // a delivered code raises the interrupt and arms overrun
                    if (pending_next != '0)
                    begin
                        if (ov_armed_reg)
                            flags_next[sta_pkg::FLG_OV] = 1'b1;
                        flags_next[sta_pkg::FLG_RR] = 1'b1;
                        irq_next                    = 1'b1;
                        ov_armed_next               = 1'b1;
                    end
                    if (pending_next == sta_pkg::TC_CIRCLE_C)
                        shift_up_next = 1'b0;
                    if (pending_next == '0 || pending_next[15:8] == sta_pkg::TC_CIRCLE_C[15:8])
                        rx_mode_next = 1'b0;
                    else
                        sched = sta_pkg::SCHED_RECV;
                end
            end
            default:
            begin
            end
        endcase
    end

    // result of the step; sense reports the word from before its reset
    always_comb
    begin
        result.read_code = rcode;
        if (item.action == sta_pkg::ACT_SENSE)
            result.status_word = sta_pkg::status_value(online_reg, busy_reg, flags_reg);
        else
            result.status_word = sta_pkg::status_value(online_reg, busy_next, flags_next);
        result.interrupt_request = irq_next;
        result.schedule_tick     = sched;
        result.upper_shift       = shift_up_next;
    end

    // state registers; a change of online clears the pending codes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            online_reg   <= 1'b0;
            pending_reg  <= '0;
            ov_armed_reg <= 1'b0;
            shift_up_reg <= 1'b0;
            busy_reg     <= 1'b0;
            rx_mode_reg  <= 1'b0;
            flags_reg    <= '0;
            irq_reg      <= 1'b0;
        end
        else
        begin
            if (step_en)
            begin
                pending_reg  <= pending_next;
                ov_armed_reg <= ov_armed_next;
                shift_up_reg <= shift_up_next;
                busy_reg     <= busy_next;
                rx_mode_reg  <= rx_mode_next;
                flags_reg    <= flags_next;
                irq_reg      <= irq_next;
            end
            if (cfg_we)
            begin
                online_reg <= cfg_wdata;
                if (cfg_wdata != online_reg)
                begin
                    pending_reg  <= '0;
                    ov_armed_reg <= 1'b0;
                    if (cfg_wdata)
                        shift_up_reg <= 1'b0;
                end
            end
        end
    end

endmodule

>>> dv/testbench.sv
// testbench for the typewriter terminal adapter: directed and random command beats
// depends on sta_pkg, sta_if and selectric_terminal_adapter from the hdl folder

module testbench;
    import sta_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int CYCLE_LIMIT     = 300000;
    localparam int PHASE_BEATS     = 210;
    localparam int FULL_RATE_BEATS = 100;

    // bus command codes the adapter ignores
    localparam logic [2:0] ACT_UNKNOWN_LO = 3'd5;
    localparam logic [2:0] ACT_UNKNOWN_HI = 3'd7;

    typedef enum logic [1:0] {KEY_NONE, KEY_PLAIN, KEY_LOWER, KEY_UPPER} key_kind_e;

    typedef struct packed {
        key_kind_e  kind;
        logic [7:0] code;
    } glyph_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    sta_cmd_if cmd();
    sta_rsp_if rsp();

    selectric_terminal_adapter i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .rsp       (rsp)
    );

    // adapter state as predicted
    logic        line_online  = 1'b0;
    logic [15:0] pend_codes   = '0;
    logic        overrun_arm  = 1'b0;
    logic        upper_case   = 1'b0;
    logic        busy_sending = 1'b0;
    logic        in_receive   = 1'b0;
    logic        irq_level    = 1'b0;
    logic [2:0]  dev_flags    = '0;

    rsp_t expected_rsp_q[$];
    int   errors     = 0;
    int   beats_sent = 0;
    bit   sender_idles    = 1'b1;
    bit   receiver_stalls = 1'b1;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // watchdog
    initial
    begin : watchdog
        int n;
        n = 0;
        while (n < CYCLE_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // ascii to typewriter key: which case of the key, and its code
    function automatic glyph_t glyph_of(input logic [7:0] ch);
        glyph_t g;
        g = '{KEY_NONE, 8'h00};
        case (ch)
            8'h20: g = '{KEY_PLAIN, 8'h01};                                  // space
            8'h0D: g = '{KEY_PLAIN, 8'h5B};                                  // carriage return
            8'h08: g = '{KEY_PLAIN, 8'h5D};                                  // backspace
            8'h09: g = '{KEY_PLAIN, 8'h5E};                                  // tab
            8'h41: g = '{KEY_LOWER, 8'h4F};  8'h61: g = '{KEY_UPPER, 8'h4F};  // A a
            8'h42: g = '{KEY_LOWER, 8'h37};  8'h62: g = '{KEY_UPPER, 8'h37};  // B b
            8'h43: g = '{KEY_LOWER, 8'h2F};  8'h63: g = '{KEY_UPPER, 8'h2F};  // C c
            8'h44: g = '{KEY_LOWER, 8'h2A};  8'h64: g = '{KEY_UPPER, 8'h2A};  // D d
            8'h45: g = '{KEY_LOWER, 8'h29};  8'h65: g = '{KEY_UPPER, 8'h29};  // E e
            8'h46: g = '{KEY_LOWER, 8'h67};  8'h5F: g = '{KEY_UPPER, 8'h67};  // F _
            8'h47: g = '{KEY_LOWER, 8'h62};  8'h67: g = '{KEY_UPPER, 8'h62};  // G g
            8'h48: g = '{KEY_LOWER, 8'h32};  8'h68: g = '{KEY_UPPER, 8'h32};  // H h
            8'h49: g = '{KEY_LOWER, 8'h4C};  8'h69: g = '{KEY_UPPER, 8'h4C};  // I i
            8'h4A: g = '{KEY_LOWER, 8'h61};  8'h6A: g = '{KEY_UPPER, 8'h61};  // J j
            8'h4B: g = '{KEY_LOWER, 8'h2C};  8'h27: g = '{KEY_UPPER, 8'h2C};  // K '
            8'h4C: g = '{KEY_LOWER, 8'h31};  8'h6C: g = '{KEY_UPPER, 8'h31};  // L l
            8'h4D: g = '{KEY_LOWER, 8'h43};                                  // M
            8'h4E: g = '{KEY_LOWER, 8'h25};  8'h6E: g = '{KEY_UPPER, 8'h25};  // N n
            8'h4F: g = '{KEY_LOWER, 8'h51};  8'h6F: g = '{KEY_UPPER, 8'h51};  // O o
            8'h50: g = '{KEY_LOWER, 8'h68};  8'h2A: g = '{KEY_UPPER, 8'h68};  // P *
            8'h51: g = '{KEY_LOWER, 8'h6D};                                  // Q
            8'h52: g = '{KEY_LOWER, 8'h4A};  8'h72: g = '{KEY_UPPER, 8'h4A};  // R r
            8'h53: g = '{KEY_LOWER, 8'h52};  8'h73: g = '{KEY_UPPER, 8'h52};  // S s
            8'h54: g = '{KEY_LOWER, 8'h20};  8'h7E: g = '{KEY_UPPER, 8'h20};  // T ~
            8'h55: g = '{KEY_LOWER, 8'h26};  8'h75: g = '{KEY_UPPER, 8'h26};  // U u
            8'h56: g = '{KEY_LOWER, 8'h46};  8'h76: g = '{KEY_UPPER, 8'h46};  // V v
            8'h57: g = '{KEY_LOWER, 8'h57};  8'h77: g = '{KEY_UPPER, 8'h57};  // W w
            8'h58: g = '{KEY_LOWER, 8'h23};  8'h78: g = '{KEY_UPPER, 8'h23};  // X x
            8'h59: g = '{KEY_LOWER, 8'h73};  8'h79: g = '{KEY_UPPER, 8'h73};  // Y y
            8'h5A: g = '{KEY_LOWER, 8'h15};  8'h7A: g = '{KEY_UPPER, 8'h15};  // Z z
            8'h30: g = '{KEY_LOWER, 8'h13};  8'h26: g = '{KEY_UPPER, 8'h13};  // 0 &
            8'h31: g = '{KEY_LOWER, 8'h02};                                  // 1
            8'h32: g = '{KEY_LOWER, 8'h04};                                  // 2
            8'h33: g = '{KEY_LOWER, 8'h07};                                  // 3
            8'h34: g = '{KEY_LOWER, 8'h10};                                  // 4
            8'h35: g = '{KEY_LOWER, 8'h08};  8'h3D: g = '{KEY_UPPER, 8'h08};  // 5 =
            8'h36: g = '{KEY_LOWER, 8'h0D};                                  // 6
            8'h37: g = '{KEY_LOWER, 8'h0B};                                  // 7
            8'h38: g = '{KEY_LOWER, 8'h0E};                                  // 8
            8'h39: g = '{KEY_LOWER, 8'h16};  8'h7C: g = '{KEY_UPPER, 8'h16};  // 9 |
            8'h2F: g = '{KEY_LOWER, 8'h70};  8'h5C: g = '{KEY_UPPER, 8'h70};  // / backslash
            8'h2B: g = '{KEY_LOWER, 8'h76};  8'h2D: g = '{KEY_UPPER, 8'h76};  // + -
            8'h3F: g = '{KEY_LOWER, 8'h64};                                  // ?
            8'h3C: g = '{KEY_LOWER, 8'h40};  8'h3E: g = '{KEY_UPPER, 8'h40};  // < >
            8'h5B: g = '{KEY_LOWER, 8'h6B};  8'h28: g = '{KEY_UPPER, 8'h6B};  // [ (
            8'h5D: g = '{KEY_LOWER, 8'h49};  8'h29: g = '{KEY_UPPER, 8'h49};  // ] )
            8'h2C: g = '{KEY_LOWER, 8'h6E};  8'h3B: g = '{KEY_UPPER, 8'h6E};  // , ;
            8'h2E: g = '{KEY_LOWER, 8'h45};  8'h3A: g = '{KEY_UPPER, 8'h45};  // . :
            default: g = '{KEY_NONE, 8'h00};
        endcase
        return g;
    endfunction

    // host character to one or two typewriter codes, shifting case as needed
    function automatic logic [15:0] ascii_to_typewriter(input logic [7:0] ch);
        glyph_t      g;
        logic [15:0] codes;
        g     = glyph_of(ch);
        codes = '0;
        if (ch == ASCII_NL)
            codes = TC_RETURN | (TC_CIRCLE_C >> 8);
        else
        begin
            case (g.kind)
                KEY_PLAIN: codes = {g.code, 8'h00};
                KEY_LOWER:
                begin
                    if (upper_case)
                    begin
                        upper_case = 1'b0;
                        codes = TC_SHIFT_DOWN | {8'h00, g.code};
                    end
                    else
                        codes = {g.code, 8'h00};
                end
                KEY_UPPER:
                begin
                    if (!upper_case)
                    begin
                        upper_case = 1'b1;
                        codes = TC_SHIFT_UP | {8'h00, g.code};
                    end
                    else
                        codes = {g.code, 8'h00};
                end
                default: codes = '0;
            endcase
        end
        return codes;
    endfunction

    function automatic logic [15:0] dsw_from_state();
        logic [15:0] w;
        w = '0;
        if (!line_online || busy_sending) w = w | DSW_TX_NOT_READY;
        if (dev_flags[FLG_RR])            w = w | DSW_READ_RESP;
        if (dev_flags[FLG_OV])            w = w | DSW_OVERRUN;
        if (dev_flags[FLG_AT])            w = w | DSW_ATTENTION;
        return w;
    endfunction

    function automatic void apply_online(input logic value);
        if (value != line_online)
        begin
            pend_codes  = '0;
            overrun_arm = 1'b0;
            if (value) upper_case = 1'b0;
        end
        line_online = value;
    endfunction

    // one command beat through the adapter state, giving the expected response
    function automatic rsp_t adapter_step(input cmd_t c);
        rsp_t        r;
        logic [15:0] sw;
        logic        have_sw;
        r       = '0;
        sw      = '0;
        have_sw = 1'b0;
        r.schedule_tick = SCHED_NONE;
        case (c.action)
            ACT_READ:
            begin
                r.read_code = pend_codes[15:8];
                overrun_arm = 1'b0;
            end
            ACT_WRITE:
            begin
                busy_sending = 1'b1;
                if ({c.write_code, 8'h00} == TC_SHIFT_UP)
                    upper_case = 1'b1;
                else if ({c.write_code, 8'h00} == TC_SHIFT_DOWN)
                    upper_case = 1'b0;
                r.schedule_tick = SCHED_SEND;
            end
            ACT_SENSE:
            begin
                sw      = dsw_from_state();
                have_sw = 1'b1;
                if (c.reset_interrupt)
                begin
                    dev_flags[FLG_RR] = 1'b0;
                    irq_level         = 1'b0;
                end
            end
            ACT_CONTROL:
            begin
                in_receive = 1'b1;
                if (line_online && (pend_codes != 0 || c.host_data_available))
                begin
                    r.schedule_tick = SCHED_RECV;
                    pend_codes      = TC_CIRCLE_D >> 8;
                end
            end
            ACT_TICK:
            begin
                busy_sending = 1'b0;
                if (in_receive)
                begin
                    pend_codes = pend_codes << 8;
                    if (pend_codes == 0 && line_online && c.host_data_available)
                    begin
                        if (c.host_char == ASCII_ETB)
                        begin
                            pend_codes        = TC_LINE_FEED;
                            dev_flags[FLG_AT] = 1'b1;
                        end
                        else
                            pend_codes = ascii_to_typewriter(c.host_char);
                    end
                    if (pend_codes != 0)
                    begin
                        if (overrun_arm) dev_flags[FLG_OV] = 1'b1;
                        dev_flags[FLG_RR] = 1'b1;
                        irq_level         = 1'b1;
                        overrun_arm       = 1'b1;
                    end
                    if (pend_codes == TC_CIRCLE_C) upper_case = 1'b0;
                    if (pend_codes == 0 || pend_codes[15:8] == TC_CIRCLE_C[15:8])
                        in_receive = 1'b0;
                    else
                        r.schedule_tick = SCHED_RECV;
                end
            end
            default: ;
        endcase
        if (!have_sw) sw = dsw_from_state();
        r.status_word       = sw;
        r.interrupt_request = irq_level;
        r.upper_shift       = upper_case;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    // prediction on each accepted command beat, comparison on each response beat
    always @(posedge clk)
    begin : scoreboard
        cmd_t beat;
        rsp_t want;
        rsp_t seen;
        if (rst_n)
        begin
            if (cfg_we) apply_online(cfg_wdata);
            if (cmd.valid && cmd.ready)
            begin
                beat = {cmd.action, cmd.write_code, cmd.reset_interrupt, cmd.host_char,
                        cmd.host_data_available};
                expected_rsp_q.push_back(adapter_step(beat));
            end
            if (rsp.valid && rsp.ready)
            begin
                seen = {rsp.read_code, rsp.status_word, rsp.interrupt_request,
                        rsp.schedule_tick, rsp.upper_shift};
                if (expected_rsp_q.size() == 0)
                begin
                    $error("response beat with no command outstanding");
                    errors++;
                end
                else
                begin
                    want = expected_rsp_q.pop_front();
                    check_field("read_code", 16'(want.read_code), 16'(seen.read_code));
                    check_field("status_word", want.status_word, seen.status_word);
                    check_field("interrupt_request", 16'(want.interrupt_request),
                                16'(seen.interrupt_request));
                    check_field("schedule_tick", 16'(want.schedule_tick),
                                16'(seen.schedule_tick));
                    check_field("upper_shift", 16'(want.upper_shift), 16'(seen.upper_shift));
                end
            end
        end
    end

    // response side back-pressure in random bursts
    initial
    begin : rsp_pacing
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (receiver_stalls && $urandom_range(0, 9) == 0)
            begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge clk);
            end
            rsp.ready <= 1'b1;
        end
    end

    // one command beat; entered and left at a falling edge, valid left high
    task automatic send_beat(input logic [2:0] act, input logic [7:0] wcode,
                             input logic rst_int, input logic [7:0] ch,
                             input logic avail);
        if (sender_idles && $urandom_range(0, 7) == 0)
        begin
            cmd.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        cmd.valid               <= 1'b1;
        cmd.action              <= act;
        cmd.write_code          <= wcode;
        cmd.reset_interrupt     <= rst_int;
        cmd.host_char           <= ch;
        cmd.host_data_available <= avail;
        do @(posedge clk); while (!cmd.ready);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic tick_char(input logic [7:0] ch, input logic avail);
        send_beat(ACT_TICK, 8'($urandom), 1'($urandom), ch, avail);
    endtask

    task automatic bus_cmd(input logic [2:0] act, input logic [7:0] wcode,
                           input logic rst_int, input logic avail);
        send_beat(act, wcode, rst_int, 8'($urandom), avail);
    endtask

    // stop sending and wait out every outstanding response
    task automatic drain_results();
        cmd.valid <= 1'b0;
        while (expected_rsp_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_online(input logic value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [7:0] pick_host_char();
        int r;
        r = $urandom_range(0, 19);
        case (r)
            0:       return ASCII_NL;
            1:       return ASCII_ETB;
            2:       return ASCII_NUL;
            3:       return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(8'h20, 8'h7E));
        endcase
    endfunction

    // turnaround, then up to n ticks with host characters, reads and senses among them, until receive mode ends
    task automatic receive_session();
        int n;
        int r;
        n = $urandom_range(1, 24);
        bus_cmd(ACT_CONTROL, 8'($urandom), 1'($urandom), $urandom_range(0, 9) != 0);
        for (int i = 0; i < n && in_receive; i++)
        begin
            tick_char(pick_host_char(), $urandom_range(0, 15) != 0);
            r = $urandom_range(0, 9);
            if (r < 6)
                bus_cmd(ACT_READ, 8'($urandom), 1'($urandom), 1'($urandom));
            else if (r == 6)
                bus_cmd(ACT_SENSE, 8'($urandom), 1'($urandom), 1'($urandom));
        end
    endtask

    // writes with shift codes among them, each finished by a service tick
    task automatic write_burst();
        logic [7:0] code;
        repeat ($urandom_range(1, 4))
        begin
            case ($urandom_range(0, 3))
                0:       code = TC_SHIFT_UP[15:8];
                1:       code = TC_SHIFT_DOWN[15:8];
                default: code = 8'($urandom);
            endcase
            bus_cmd(ACT_WRITE, code, 1'($urandom), 1'($urandom));
            if ($urandom_range(0, 3) == 0)
                bus_cmd(ACT_SENSE, 8'($urandom), 1'($urandom), 1'($urandom));
            tick_char(8'($urandom), 1'($urandom));
        end
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(1, 6))
            send_beat(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
                      8'($urandom), 1'($urandom));
    endtask

    task automatic mixed_traffic(input int target);
        int r;
        while (beats_sent < target)
        begin
            r = $urandom_range(0, 9);
            if (r < 7)
                receive_session();
            else if (r < 9)
                write_burst();
            else
                noise_burst();
        end
    endtask

    // terminal detached: writes, shift codes, offline turnaround and tick, unused codes
    task automatic test_offline_commands();
        set_online(1'b0);
        bus_cmd(ACT_SENSE, 8'h00, 1'b0, 1'b0);
        bus_cmd(ACT_WRITE, TC_SHIFT_UP[15:8], 1'b0, 1'b0);
        bus_cmd(ACT_WRITE, 8'hFF, 1'b1, 1'b1);
        tick_char(8'hFF, 1'b1);
        bus_cmd(ACT_WRITE, TC_SHIFT_DOWN[15:8], 1'b0, 1'b0);
        bus_cmd(ACT_CONTROL, 8'h00, 1'b0, 1'b1);
        tick_char(ASCII_ETB, 1'b1);
        bus_cmd(ACT_READ, 8'h00, 1'b0, 1'b0);
        send_beat(ACT_UNKNOWN_LO, 8'h00, 1'b0, 8'h00, 1'b0);
        send_beat(ACT_UNKNOWN_HI, 8'hFF, 1'b1, 8'hFF, 1'b1);
    endtask

    // terminal attached: shift prefixes, newline, overrun, attention, end of input
    task automatic test_receive_translation();
        set_online(1'b1);
        bus_cmd(ACT_CONTROL, 8'h00, 1'b0, 1'b1);
        tick_char(8'h61, 1'b1);
        bus_cmd(ACT_READ, 8'h00, 1'b0, 1'b0);
        tick_char(8'h61, 1'b1);
        bus_cmd(ACT_READ, 8'h00, 1'b0, 1'b0);
        tick_char(8'h41, 1'b1);
        tick_char(ASCII_NL, 1'b1);
        tick_char(8'h00, 1'b1);
        bus_cmd(ACT_SENSE, 8'h00, 1'b1, 1'b0);
        bus_cmd(ACT_SENSE, 8'h00, 1'b0, 1'b0);
        bus_cmd(ACT_CONTROL, 8'h00, 1'b0, 1'b1);
        tick_char(8'h20, 1'b1);
        tick_char(ASCII_ETB, 1'b1);
        tick_char(8'h41, 1'b0);
        bus_cmd(ACT_CONTROL, 8'h00, 1'b0, 1'b0);
        tick_char(ASCII_NUL, 1'b1);
    endtask

    // random sessions over several online settings, with one full pause
    task automatic test_random_sessions();
        bit [5:0] online_plan;
        online_plan = 6'b101101;
        for (int p = 0; p < 6; p++)
        begin
            set_online(online_plan[p]);
            if (p == 2)
            begin
                mixed_traffic(beats_sent + PHASE_BEATS / 2);
                drain_results();
                mixed_traffic(beats_sent + PHASE_BEATS / 2);
            end
            else
                mixed_traffic(beats_sent + PHASE_BEATS);
        end
    endtask

    // back to back beats with no idling on either side
    task automatic test_full_rate();
        drain_results();
        sender_idles    = 1'b0;
        receiver_stalls = 1'b0;
        set_online(1'b1);
        mixed_traffic(beats_sent + FULL_RATE_BEATS);
    endtask

    initial
    begin
        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_wdata               = 1'b0;
        cmd.valid               = 1'b0;
        cmd.action              = ACT_READ;
        cmd.write_code          = '0;
        cmd.reset_interrupt     = 1'b0;
        cmd.host_char           = '0;
        cmd.host_data_available = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_offline_commands();
        test_receive_translation();
        test_random_sessions();
        test_full_rate();

        drain_results();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
